// File: rtl/core/hpl_pkg.sv
package hpl_pkg;

   localparam int WEIGHT_W = 16;
   localparam int NODE_W   = 24;
   localparam int PATH_W   = 32;
   localparam int COUNT_W  = 7;

   typedef struct packed {
      logic load;
      logic scan_start;
      logic take_a;
      logic merge;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic found;
      logic out_free;
   } status_type;

endpackage

// File: rtl/core/hpl_if.sv
interface hpl_req_if;
   import hpl_pkg::*;

   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] weight;
   logic                last;

   modport source (output valid, output weight, output last, input ready);
   modport sink   (input valid, input weight, input last, output ready);
endinterface

interface hpl_rsp_if;
   import hpl_pkg::*;

   logic               valid;
   logic               ready;
   logic [PATH_W-1:0]  path_length;
   logic [COUNT_W-1:0] symbol_count;
   logic               overflow;

   modport source (output valid, output path_length, output symbol_count, output overflow,
                   input ready);
   modport sink   (input valid, input path_length, input symbol_count, input overflow,
                   output ready);
endinterface

// File: rtl/core/hpl_ctrl.sv
module hpl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last,
   output logic                req_ready,
   input  hpl_pkg::status_type status,
   output hpl_pkg::cmd_type    cmd
);
   import hpl_pkg::*;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN_A,
      ST_SCAN_B,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == ST_LOAD);
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            cmd.scan_start = 1'b1;
            state_in       = ST_SCAN_A;
         end
         ST_SCAN_A: begin
            if (status.scan_done) begin
               if (status.found) begin
                  cmd.take_a     = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_B;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN_B: begin
            if (status.scan_done) begin
               if (status.found) begin
                  cmd.merge      = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_SCAN_A;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/core/hpl_datapath.sv
module hpl_datapath #(
   parameter int MAX_SYMBOLS = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  hpl_pkg::cmd_type              cmd,
   output hpl_pkg::status_type           status,
   input  logic [hpl_pkg::WEIGHT_W-1:0]  req_weight,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hpl_pkg::PATH_W-1:0]    rsp_path_length,
   output logic [hpl_pkg::COUNT_W-1:0]   rsp_symbol_count,
   output logic                          rsp_overflow
);
   import hpl_pkg::*;

   localparam int DEPTH = 2 * MAX_SYMBOLS;
   localparam int NW    = $clog2(DEPTH);

   logic [NODE_W-1:0] node_mem [DEPTH];
   logic [DEPTH-1:0]  used_ff;

   logic [NW-1:0]     count_ff;
   logic [NW-1:0]     nodes_ff;
   logic [NW-1:0]     scan_idx_ff;
   logic [NW-1:0]     pend_idx_ff;
   logic [NW-1:0]     best_idx_ff;
   logic              issue_ff;
   logic              active_ff;
   logic              pend_ff;
   logic              pend_used_ff;
   logic              best_found_ff;
   logic [NODE_W-1:0] rd_data_ff;
   logic [NODE_W-1:0] best_w_ff;
   logic [NODE_W-1:0] w_a_ff;
   logic [PATH_W-1:0] total_ff;
   logic              dropped_ff;
   logic              sat_ff;

   logic                  rsp_valid_ff;
   logic [PATH_W-1:0]     path_out_ff;
   logic [COUNT_W-1:0]    count_out_ff;
   logic                  ovf_out_ff;

   logic                  store;
   logic                  scan_more;
   logic                  scan_done;
   logic                  better;
   logic                  wr_en;
   logic [NW-1:0]         wr_addr;
   logic [NODE_W-1:0]     wr_data;
   logic [NODE_W:0]       sum_wide;
   logic [NODE_W-1:0]     sum;
   logic [PATH_W:0]       total_wide;
   logic [NW+COUNT_W-1:0] count_ext;

   assign store      = cmd.load && (count_ff < NW'(MAX_SYMBOLS));
   assign scan_more  = scan_idx_ff < nodes_ff;
   assign scan_done  = active_ff && !issue_ff && !pend_ff;
   assign better     = pend_ff && !pend_used_ff && (!best_found_ff || rd_data_ff < best_w_ff);
   assign sum_wide   = {1'b0, w_a_ff} + {1'b0, best_w_ff};
   assign sum        = sum_wide[NODE_W-1:0];
   assign total_wide = {1'b0, total_ff} + {{(PATH_W + 1 - NODE_W){1'b0}}, sum};
   assign count_ext  = {{COUNT_W{1'b0}}, count_ff};

   assign wr_en   = store || cmd.merge;
   assign wr_addr = cmd.merge ? nodes_ff : count_ff;
   assign wr_data = cmd.merge ? sum : NODE_W'(req_weight);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      if (issue_ff && scan_more) begin
         rd_data_ff <= node_mem[scan_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         count_ff      <= '0;
         nodes_ff      <= '0;
         issue_ff      <= 1'b0;
         active_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         best_found_ff <= 1'b0;
         total_ff      <= '0;
         dropped_ff    <= 1'b0;
         sat_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_ff <= issue_ff && scan_more;
         if (issue_ff && scan_more) begin
            scan_idx_ff  <= scan_idx_ff + 1'b1;
            pend_idx_ff  <= scan_idx_ff;
            pend_used_ff <= used_ff[scan_idx_ff];
         end else if (issue_ff) begin
            issue_ff <= 1'b0;
         end
         if (better) begin
            best_found_ff <= 1'b1;
            best_w_ff     <= rd_data_ff;
            best_idx_ff   <= pend_idx_ff;
         end
         if (cmd.scan_start) begin
            active_ff     <= 1'b1;
            issue_ff      <= 1'b1;
            scan_idx_ff   <= '0;
            best_found_ff <= 1'b0;
         end else if (scan_done) begin
            active_ff <= 1'b0;
         end

         if (store) begin
            count_ff <= count_ff + 1'b1;
            nodes_ff <= nodes_ff + 1'b1;
         end else if (cmd.load) begin
            dropped_ff <= 1'b1;
         end

         if (cmd.take_a) begin
            used_ff[best_idx_ff] <= 1'b1;
            w_a_ff               <= best_w_ff;
         end

         if (cmd.merge) begin
            used_ff[best_idx_ff] <= 1'b1;
            nodes_ff             <= nodes_ff + 1'b1;
            if (total_wide[PATH_W]) begin
               total_ff <= '1;
               sat_ff   <= 1'b1;
            end else begin
               total_ff <= total_wide[PATH_W-1:0];
            end
         end

         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.finish) begin
            path_out_ff  <= total_ff;
            count_out_ff <= count_ext[COUNT_W-1:0];
            ovf_out_ff   <= dropped_ff || sat_ff;
            used_ff      <= '0;
            count_ff     <= '0;
            nodes_ff     <= '0;
            total_ff     <= '0;
            dropped_ff   <= 1'b0;
            sat_ff       <= 1'b0;
         end
      end
   end

   assign status.scan_done = scan_done;
   assign status.found     = best_found_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_path_length  = path_out_ff;
   assign rsp_symbol_count = count_out_ff;
   assign rsp_overflow     = ovf_out_ff;

endmodule

// File: rtl/core/huffman_path_length_unit.sv
// Weight requests are taken while the controller sits in its load state; after the last one
// the tree is built by merges, each after two min searches over the nodes written so far.
// Throughput: set by the min search, which reads the node memory one entry per cycle.
// The result sits in an output register; the next set loads while it waits.
// Reset: synchronous, active high; clears control, counts and node-used flags at once.
module huffman_path_length_unit #(
   parameter int MAX_SYMBOLS = 64
) (
   input  logic             clock,
   input  logic             reset,
   hpl_req_if.sink          req_chan,
   hpl_rsp_if.source        rsp_chan
);
   import hpl_pkg::*;

   cmd_type    cmd;
   status_type status;

   hpl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hpl_datapath #(
      .MAX_SYMBOLS (MAX_SYMBOLS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_weight       (req_chan.weight),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_path_length  (rsp_chan.path_length),
      .rsp_symbol_count (rsp_chan.symbol_count),
      .rsp_overflow     (rsp_chan.overflow)
   );

endmodule

// File: rtl/core/hpl_checker.sv
module hpl_checker #(
   parameter int MAX_SYMBOLS = 64
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [hpl_pkg::PATH_W-1:0]    path_length,
   input logic [hpl_pkg::COUNT_W-1:0]   symbol_count,
   input logic                          overflow
);
   import hpl_pkg::*;

   localparam logic SMALL_SET = (MAX_SYMBOLS < 128);

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(path_length)
         && $stable(symbol_count) && $stable(overflow))
      else $error("stalled response changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_SET |-> symbol_count <= COUNT_W'(MAX_SYMBOLS))
      else $error("symbol count above capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_SET && symbol_count < COUNT_W'(MAX_SYMBOLS) |-> !overflow)
      else $error("overflow without a full set");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && SMALL_SET && symbol_count == COUNT_W'(1) |-> path_length == '0)
      else $error("single symbol with nonzero path length");

endmodule

bind huffman_path_length_unit hpl_checker #(
   .MAX_SYMBOLS (MAX_SYMBOLS)
) u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .path_length  (rsp_chan.path_length),
   .symbol_count (rsp_chan.symbol_count),
   .overflow     (rsp_chan.overflow)
);
